// ===== hw/rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment look-up for the multiplexed
// seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int NUM_DIGITS   = 6;
	localparam int IDX_W        = $clog2(NUM_DIGITS);
	localparam int CODE_W       = 4;
	localparam int SEG_W        = 8;
	localparam int EN_W         = 6;
	localparam int MASK_W       = 6;
	localparam int POS_W        = 3;
	localparam int NUM_W        = 32;

	// largest magnitudes that still fit on the display
	localparam longint POS_MAX  = (64'd10 ** NUM_DIGITS) - 1;
	localparam longint NEG_MAX  = (64'd10 ** (NUM_DIGITS - 1)) - 1;

	// bits of magnitude shifted through the BCD converter
	localparam int BCD_STEPS    = $clog2(POS_MAX + 1);
	localparam int CNT_W        = $clog2(BCD_STEPS + 1);

	localparam logic [CODE_W-1:0] CODE_MINUS = 4'd11;
	localparam logic [CODE_W-1:0] CODE_H     = 4'd12;
	localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

	localparam logic [POS_W-1:0] POS_NONE_RESET = 3'd6;
	localparam logic [POS_W-1:0] POS_NONE_INT   = 3'd7;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_POINT = 2'd2,
		KIND_INT   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [MASK_W-1:0]         digit_mask;
		logic [CODE_W-1:0]         char_code;
		logic [POS_W-1:0]          point_position;
		logic signed [NUM_W-1:0]   number;
	} cmd_t;

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [EN_W-1:0]  digit_enable;
	} disp_t;

	typedef logic [NUM_DIGITS-1:0][CODE_W-1:0] digits_t;

	function automatic logic [SEG_W-2:0] seg_pattern(input logic [CODE_W-1:0] code);
		logic [SEG_W-2:0] pat;
		case (code)
			4'd0:    pat = 7'd63;
			4'd1:    pat = 7'd6;
			4'd2:    pat = 7'd91;
			4'd3:    pat = 7'd79;
			4'd4:    pat = 7'd102;
			4'd5:    pat = 7'd109;
			4'd6:    pat = 7'd125;
			4'd7:    pat = 7'd7;
			4'd8:    pat = 7'd127;
			4'd9:    pat = 7'd111;
			4'd11:   pat = 7'd64;
			4'd12:   pat = 7'h76;
			default: pat = 7'd0;
		endcase
		return pat;
	endfunction

endpackage

// ===== hw/rtl/ssd_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// ssd_bcd_conv
// Bit-serial binary to BCD converter (shift and add three), one magnitude
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ssd_bcd_conv (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ssd_pkg::BCD_STEPS-1:0]       mag,
	output logic                                done,
	output ssd_pkg::digits_t                    digits
);
	import ssd_pkg::*;

	logic [BCD_STEPS-1:0] sh_q;
	digits_t              bcd_q;
	digits_t              adj;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// correct each digit before it doubles
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BCD_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q     <= {sh_q[BCD_STEPS-2:0], 1'b0};
			bcd_q[0] <= {adj[0][2:0], sh_q[BCD_STEPS-1]};
			for (int i = 1; i < NUM_DIGITS; i++) begin
				bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

// ===== hw/rtl/seven_segment_scan_with_int_display_top.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_with_int_display_top
// Six-digit multiplexed seven-segment controller: digit store, scan counter,
// segment decode and signed integer rendering through a serial BCD converter.
// ----------------------------------------------------------------------------
// A scan tick's result is in the output register in the cycle after the
// transaction. Tick, write and point transactions go at one per cycle while
// the output register can take a result and no integer is in conversion. A
// show-integer transaction holds the command channel while the converter
// takes one magnitude bit per cycle; an out-of-range value shows H at once.
// Reset blanks every digit, clears the point and sets the scan index to digit 0.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_int_display_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  ssd_pkg::cmd_t   cmd,
	output logic            disp_valid,
	input  logic            disp_stall,
	output ssd_pkg::disp_t  disp
);
	import ssd_pkg::*;

	digits_t                codes_q;
	logic [POS_W-1:0]       point_q;
	logic [IDX_W-1:0]       scan_q;
	logic                   busy_q;
	logic                   neg_q;
	logic                   disp_valid_q;
	disp_t                  disp_q;

	logic                   accept;
	logic                   out_take;
	logic [IDX_W-1:0]       scan_nxt;
	logic                   num_neg;
	logic [NUM_W-1:0]       num_mag;
	logic                   num_over;
	logic                   conv_start;
	logic                   conv_done;
	digits_t                conv_digits;
	logic [NUM_DIGITS-1:0]  sig;
	digits_t                rendered;

	assign out_take  = disp_valid_q && !disp_stall;
	assign cmd_stall = busy_q || (disp_valid_q && disp_stall);
	assign accept    = cmd_valid && !cmd_stall;

	assign scan_nxt = (scan_q == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_q + 1'b1;

	assign num_neg  = cmd.number[NUM_W-1];
	assign num_mag  = num_neg ? (~cmd.number + 1'b1) : cmd.number;
	assign num_over = num_neg ? ({32'd0, num_mag} > 64'(NEG_MAX))
	                          : ({32'd0, num_mag} > 64'(POS_MAX));

	assign conv_start = accept && (cmd.kind == KIND_INT) && !num_over;

	ssd_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.mag    (num_mag[BCD_STEPS-1:0]),
		.done   (conv_done),
		.digits (conv_digits)
	);

	// a digit is significant if it or any digit above it is non-zero; digit 0 always is
	always_comb begin
		sig[NUM_DIGITS-1] = (conv_digits[NUM_DIGITS-1] != '0);
		for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
			sig[i] = sig[i+1] || (conv_digits[i] != '0);
		end
		sig[0] = 1'b1;
		rendered[0] = conv_digits[0];
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (sig[i]) begin
				rendered[i] = conv_digits[i];
			end else if (neg_q && sig[i-1]) begin
				rendered[i] = CODE_MINUS;
			end else begin
				rendered[i] = CODE_BLANK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				codes_q[i] <= CODE_BLANK;
			end
			point_q      <= POS_NONE_RESET;
			scan_q       <= '0;
			busy_q       <= 1'b0;
			neg_q        <= 1'b0;
			disp_valid_q <= 1'b0;
		end else begin
			// load on a tick, drop once the display side takes it
			disp_valid_q <= (accept && (cmd.kind == KIND_TICK)) || (disp_valid_q && !out_take);
			if (conv_done) begin
				busy_q  <= 1'b0;
				codes_q <= rendered;
			end
			if (accept) begin
				unique case (cmd.kind)
					KIND_TICK: begin
						scan_q <= scan_nxt;
					end
					KIND_WRITE: begin
						for (int i = 0; i < NUM_DIGITS; i++) begin
							if (cmd.digit_mask[i]) begin
								codes_q[i] <= cmd.char_code;
							end
						end
					end
					KIND_POINT: begin
						point_q <= cmd.point_position;
					end
					KIND_INT: begin
						point_q <= POS_NONE_INT;
						if (num_over) begin
							for (int i = 0; i < NUM_DIGITS; i++) begin
								codes_q[i] <= CODE_H;
							end
						end else begin
							busy_q <= 1'b1;
							neg_q  <= num_neg;
						end
					end
					default: begin
						busy_q <= busy_q;
					end
				endcase
			end
		end
	end

	// hold the result until the transaction on the display side
	always_ff @(posedge clk) begin
		if (accept && (cmd.kind == KIND_TICK)) begin
			disp_q.segments     <= {(POS_W'(scan_nxt) == point_q),
			                        seg_pattern(codes_q[scan_nxt])};
			disp_q.digit_enable <= EN_W'(1) << scan_nxt;
		end
	end

	assign disp_valid = disp_valid_q;
	assign disp       = disp_q;

endmodule

// ===== test/tb_seven_segment_scan_with_int_display_top.sv =====
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_with_int_display_top
// Drives digit writes, point moves, signed integers and scan ticks into the
// display driver. A short table of directed rows comes first, then random
// transactions. Every display frame is checked against a model of the digit
// store that runs in the testbench (directed rows may type the frame), with
// random sender gaps, random display stalls and one long display hold-off.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_with_int_display_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int SCRIPT_LEN   = 25;
	localparam int RANDOM_ITEMS = 1100;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_FROM    = 500;
	localparam int CALM_TO      = 600;
	localparam int QUIET_TAIL   = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam int STUCK_LIMIT  = 2000;

	// glyphs for codes 15 down to 0, seven bits each
	localparam logic [16*7-1:0] GLYPHS = {
		7'd0, 7'd0, 7'd0, 7'h76, 7'd64, 7'd0, 7'd111, 7'd127,
		7'd7, 7'd125, 7'd109, 7'd102, 7'd79, 7'd91, 7'd6, 7'd63
	};

	typedef struct {
		cmd_t  c;
		bit    typed;
		disp_t want;
	} script_row_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_stall;
	cmd_t  cmd;
	logic  disp_valid;
	logic  disp_stall;
	disp_t disp;

	// display model state
	logic [CODE_W-1:0] shown_codes [NUM_DIGITS];
	logic [POS_W-1:0]  point_at;
	logic [POS_W-1:0]  lit_digit;

	disp_t       frames_due [$];
	disp_t       frame_want;
	script_row_t script [SCRIPT_LEN];
	int unsigned errors = 0;
	bit          calm = 1'b0;
	bit          hold_go = 1'b0;
	bit          holding = 1'b0;

	seven_segment_scan_with_int_display_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.disp_valid (disp_valid),
		.disp_stall (disp_stall),
		.disp       (disp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic cmd_t make_cmd(input kind_t k, input logic [MASK_W-1:0] m,
			input logic [CODE_W-1:0] cc, input logic [POS_W-1:0] p,
			input logic signed [NUM_W-1:0] n);
		cmd_t c;
		c.kind           = k;
		c.digit_mask     = m;
		c.char_code      = cc;
		c.point_position = p;
		c.number         = n;
		return c;
	endfunction

	function automatic void clear_digits();
		shown_codes = '{default: CODE_BLANK};
		point_at    = POS_NONE_RESET;
		lit_digit   = '0;
	endfunction

	// blank everything, then lay the value in from the rightmost digit
	function automatic void render_number(input logic signed [NUM_W-1:0] value);
		longint v;
		longint mag;
		bit     negative;
		int     d;
		v        = value;
		negative = v < 0;
		mag      = negative ? -v : v;
		foreach (shown_codes[i])
			shown_codes[i] = CODE_BLANK;
		point_at = POS_NONE_INT;
		if ((!negative && mag > POS_MAX) || (negative && mag > NEG_MAX)) begin
			foreach (shown_codes[i])
				shown_codes[i] = CODE_H;
		end else if (mag == 0) begin
			shown_codes[0] = '0;
		end else begin
			d = 0;
			while (mag > 0 && d < NUM_DIGITS) begin
				shown_codes[d] = CODE_W'(mag % 10);
				mag            = mag / 10;
				d++;
			end
			if (negative && d < NUM_DIGITS)
				shown_codes[d] = CODE_MINUS;
		end
	endfunction

	// apply one accepted command; returns 1 when it produces a display frame
	function automatic bit apply_cmd(input cmd_t c, output disp_t frame);
		frame = '0;
		case (c.kind)
			KIND_TICK: begin
				lit_digit = (lit_digit == POS_W'(NUM_DIGITS - 1)) ? '0 : lit_digit + 1'b1;
				frame.segments     = {lit_digit == point_at,
					GLYPHS[shown_codes[lit_digit]*7 +: 7]};
				frame.digit_enable = EN_W'(1) << lit_digit;
				return 1'b1;
			end
			KIND_WRITE: begin
				foreach (shown_codes[i])
					if (c.digit_mask[i])
						shown_codes[i] = c.char_code;
			end
			KIND_POINT: point_at = c.point_position;
			default:    render_number(c.number);
		endcase
		return 1'b0;
	endfunction

	function automatic logic signed [NUM_W-1:0] random_number();
		logic signed [NUM_W-1:0] edges [8];
		edges = '{999999, 1000000, -99999, -100000, 0, -1, 32'sh7fffffff, 32'sh80000000};
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 99);
			1:       return $urandom_range(0, 999999);
			2:       return -$signed($urandom_range(1, 99999));
			3:       return -$signed($urandom_range(1, 999));
			4:       return edges[$urandom_range(0, 7)];
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned pick;
		c.digit_mask     = MASK_W'($urandom);
		c.char_code      = CODE_W'($urandom);
		c.point_position = POS_W'($urandom);
		c.number         = random_number();
		pick             = $urandom_range(0, 99);
		if (pick < 50)
			c.kind = KIND_TICK;
		else if (pick < 68)
			c.kind = KIND_WRITE;
		else if (pick < 78)
			c.kind = KIND_POINT;
		else
			c.kind = KIND_INT;
		return c;
	endfunction

	// offer one transaction and hold it until accepted
	task automatic offer(input cmd_t c);
		disp_t frame;
		bit    has_frame;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		has_frame = apply_cmd(c, frame);
		if (has_frame)
			frames_due.push_back(frame);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		@(negedge clk);
		cmd_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!calm && !holding && !hold_go && $urandom_range(0, 5) == 0)
			idle_sender($urandom_range(1, 14));
	endtask

	// display receiver: random stall bursts and one long hold-off
	initial begin
		disp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go    = 1'b0;
				holding    = 1'b1;
				disp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				disp_stall <= 1'b0;
				holding    = 1'b0;
			end else if (!calm && arst_n && $urandom_range(0, 7) == 0) begin
				disp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				disp_stall <= 1'b0;
			end else begin
				disp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && disp_valid && !disp_stall) begin
			if (frames_due.size() == 0) begin
				flag_mismatch("frame with none expected", disp, 0);
			end else begin
				frame_want = frames_due.pop_front();
				if (disp.segments !== frame_want.segments)
					flag_mismatch("segments", disp.segments, frame_want.segments);
				if (disp.digit_enable !== frame_want.digit_enable)
					flag_mismatch("digit_enable", disp.digit_enable, frame_want.digit_enable);
			end
		end
	end

	// watchdog: cycles in which neither channel moves a transaction
	initial begin
		int unsigned stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (disp_valid && !disp_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		disp_t frame;
		bit    has_frame;

		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		clear_digits();

		script[0]  = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd0, 6'b000010}};
		script[1]  = '{make_cmd(KIND_WRITE, 6'h3f, 4'd8, '0, 0), 1'b0, '0};
		script[2]  = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd127, 6'b000100}};
		script[3]  = '{make_cmd(KIND_POINT, '0, '0, 3'd3, 0), 1'b0, '0};
		script[4]  = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd255, 6'b001000}};
		script[5]  = '{make_cmd(KIND_WRITE, 6'b010000, 4'd13, '0, 0), 1'b0, '0};
		script[6]  = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd0, 6'b010000}};
		script[7]  = '{make_cmd(KIND_WRITE, 6'b100000, 4'd14, '0, 0), 1'b0, '0};
		script[8]  = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b0, '0};
		script[9]  = '{make_cmd(KIND_POINT, '0, '0, 3'd0, 0), 1'b0, '0};
		script[10] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd255, 6'b000001}};
		script[11] = '{make_cmd(KIND_INT, '0, '0, '0, 0), 1'b0, '0};
		script[12] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd0, 6'b000010}};
		script[13] = '{make_cmd(KIND_INT, '0, '0, '0, 1000000), 1'b0, '0};
		script[14] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'h76, 6'b000100}};
		script[15] = '{make_cmd(KIND_INT, '0, '0, '0, -99999), 1'b0, '0};
		script[16] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b0, '0};
		script[17] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b0, '0};
		script[18] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'd64, 6'b100000}};
		script[19] = '{make_cmd(KIND_INT, '0, '0, '0, 32'sh80000000), 1'b0, '0};
		script[20] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b1, '{8'h76, 6'b000001}};
		script[21] = '{make_cmd(KIND_INT, '0, '0, '0, 999999), 1'b0, '0};
		script[22] = '{make_cmd(KIND_WRITE, 6'b000011, 4'd10, '0, 0), 1'b0, '0};
		script[23] = '{make_cmd(KIND_TICK, '0, '0, '0, 0), 1'b0, '0};
		script[24] = '{make_cmd(KIND_INT, '0, '0, '0, -1), 1'b0, '0};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// typed rows replace the model's frame, but still advance its state
		foreach (script[r]) begin
			maybe_idle();
			@(negedge clk);
			cmd_valid <= 1'b1;
			cmd       <= script[r].c;
			do @(posedge clk); while (cmd_stall);
			has_frame = apply_cmd(script[r].c, frame);
			if (has_frame)
				frames_due.push_back(script[r].typed ? script[r].want : frame);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= CALM_FROM && n < CALM_TO) || n >= QUIET_TAIL;
			if (n == HOLD_AT)
				hold_go = 1'b1;
			maybe_idle();
			offer(random_cmd());
		end
		@(negedge clk);
		cmd_valid <= 1'b0;

		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frames_due.size() != 0)
			flag_mismatch("frames never produced", frames_due.size(), 0);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== seven_segment_scan_with_int_display_top.f =====
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_bcd_conv.sv
hw/rtl/seven_segment_scan_with_int_display_top.sv
test/tb_seven_segment_scan_with_int_display_top.sv
